// ----- rtl/hsv2rgb_pkg.sv -----
// Shared types and constants for the HSV to RGB pixel converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

    typedef struct packed {
        logic [8:0] hue_deg;
        logic [6:0] sat_pct;
        logic [6:0] val_pct;
    } hsv_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_out_t;

    // Load enables of the per-channel stages (stages three to six).
    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
        logic en6;
    } chan_en_t;

    localparam int unsigned HUE_WRAP   = 360;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned PCT_MAX    = 100;
    localparam int unsigned V_SCALE    = 6000;   // 100 * 60
    // 255 / 600000 reduces to 17 / 40000; 40000 = 64 * 625.
    localparam int unsigned CHAN_MUL   = 17;
    localparam int unsigned ROUND_OFS  = 20000;  // half of 40000
    localparam int unsigned DIV_SHIFT  = 6;
    localparam int unsigned DIV_REM    = 625;
    localparam int unsigned RECIP      = 26843;  // floor(2^24 / 625)
    localparam int unsigned RECIP_SH   = 24;
    localparam int unsigned CODE_MAX   = 255;

endpackage

// ----- rtl/hsv_to_rgb_pixel_convert.sv -----
// Top level of the HSV to RGB pixel converter: six-stage pipeline.
`timescale 1ns / 1ps

// Channel | Ports                      | Payload
// --------+----------------------------+------------------------------------
// input   | s_valid, s_ready, s_data   | hue_deg 9b, sat_pct 7b, val_pct 7b
// result  | m_valid, m_ready, m_data   | red 8b, green 8b, blue 8b
//
// One transfer in per clock while the output side is ready; each result passes
// through stages one to six in order. Stage six is the output register.
// Every stage has its own valid bit and load enable, so bubbles are squeezed
// out and a stalled output only halts the stages behind a full one.
// Reset (aresetn low, synchronous) clears the valid bits only; s_ready is
// held low while reset is applied.

module hsv_to_rgb_pixel_convert
    import hsv2rgb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  hsv_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rgb_out_t m_data
);

    // Valid bits of stages one to six (index 0 is stage one).
    logic [5:0] vld_reg, vld_next;
    logic [5:0] rdy;
    logic [5:0] vin;

    // Stage 1: hue wrapped, saturation and value limited.
    logic [8:0]  h1_reg, h1_next;
    logic [6:0]  s1_reg, s1_next;
    logic [6:0]  v1_reg, v1_next;

    // Stage 2: products and per-channel weights.
    logic [13:0] sv2_reg, sv2_next;
    logic [19:0] v6k2_reg, v6k2_next;
    logic [5:0]  wr2_reg, wr2_next;
    logic [5:0]  wg2_reg, wg2_next;
    logic [5:0]  wb2_reg, wb2_next;

    logic [2:0]  sector;
    logic [8:0]  sect_base;
    logic [5:0]  ramp;        // hue within its 60 degree sector
    logic [5:0]  xw;          // 60 - X weight
    logic [5:0]  cw;
    logic [5:0]  zw;

    chan_en_t    cen;

    // Channel codes from stage six.
    logic [7:0]  red_code;
    logic [7:0]  green_code;
    logic [7:0]  blue_code;

    // Ready chain: a stage loads when empty or when the next one loads.
    assign rdy[5] = !vld_reg[5] || m_ready;
    genvar gi;
    generate
        for (gi = 0; gi < 5; gi++) begin : g_rdy
            assign rdy[gi] = !vld_reg[gi] || rdy[gi + 1];
        end
    endgenerate

    assign vin = {vld_reg[4:0], s_valid};

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            vld_next[i] = rdy[i] ? vin[i] : vld_reg[i];
        end
    end

    assign s_ready = rdy[0] && aresetn;

    // Stage 1 next values.
    assign h1_next = (s_data.hue_deg >= 9'(HUE_WRAP)) ? s_data.hue_deg - 9'(HUE_WRAP)
                                                       : s_data.hue_deg;
    assign s1_next = (s_data.sat_pct > 7'(PCT_MAX)) ? 7'(PCT_MAX) : s_data.sat_pct;
    assign v1_next = (s_data.val_pct > 7'(PCT_MAX)) ? 7'(PCT_MAX) : s_data.val_pct;

    // Stage 2: sector by compares, ramp inside it.
    always_comb begin
        if (h1_reg < 9'(SECTOR_DEG)) begin
            sector = 3'd0;
        end else if (h1_reg < 9'(2 * SECTOR_DEG)) begin
            sector = 3'd1;
        end else if (h1_reg < 9'(3 * SECTOR_DEG)) begin
            sector = 3'd2;
        end else if (h1_reg < 9'(4 * SECTOR_DEG)) begin
            sector = 3'd3;
        end else if (h1_reg < 9'(5 * SECTOR_DEG)) begin
            sector = 3'd4;
        end else begin
            sector = 3'd5;
        end
    end

    assign sect_base = 9'(sector * 9'(SECTOR_DEG));
    assign ramp      = 6'(h1_reg - sect_base);
    // Rising edge of X in even sectors, falling in odd ones.
    assign xw        = sector[0] ? ramp : 6'(SECTOR_DEG) - ramp;
    assign cw        = 6'd0;
    assign zw        = 6'(SECTOR_DEG);

    // Which of C, X and 0 each channel takes.
    always_comb begin
        case (sector)
            3'd0: begin
                wr2_next = cw; wg2_next = xw; wb2_next = zw;
            end
            3'd1: begin
                wr2_next = xw; wg2_next = cw; wb2_next = zw;
            end
            3'd2: begin
                wr2_next = zw; wg2_next = cw; wb2_next = xw;
            end
            3'd3: begin
                wr2_next = zw; wg2_next = xw; wb2_next = cw;
            end
            3'd4: begin
                wr2_next = xw; wg2_next = zw; wb2_next = cw;
            end
            default: begin
                wr2_next = cw; wg2_next = zw; wb2_next = xw;
            end
        endcase
    end

    assign sv2_next  = 14'(s1_reg) * 14'(v1_reg);
    assign v6k2_next = 20'(v1_reg) * 20'(V_SCALE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            h1_reg <= h1_next;
            s1_reg <= s1_next;
            v1_reg <= v1_next;
        end
        if (rdy[1]) begin
            sv2_reg  <= sv2_next;
            v6k2_reg <= v6k2_next;
            wr2_reg  <= wr2_next;
            wg2_reg  <= wg2_next;
            wb2_reg  <= wb2_next;
        end
    end

    assign cen.en3 = rdy[2];
    assign cen.en4 = rdy[3];
    assign cen.en5 = rdy[4];
    assign cen.en6 = rdy[5];

    hsv2rgb_channel u_red (
        .aclk   (aclk),
        .en     (cen),
        .v6000  (v6k2_reg),
        .sv     (sv2_reg),
        .weight (wr2_reg),
        .code   (red_code)
    );

    hsv2rgb_channel u_green (
        .aclk   (aclk),
        .en     (cen),
        .v6000  (v6k2_reg),
        .sv     (sv2_reg),
        .weight (wg2_reg),
        .code   (green_code)
    );

    hsv2rgb_channel u_blue (
        .aclk   (aclk),
        .en     (cen),
        .v6000  (v6k2_reg),
        .sv     (sv2_reg),
        .weight (wb2_reg),
        .code   (blue_code)
    );

    assign m_data  = '{red: red_code, green: green_code, blue: blue_code};
    assign m_valid = vld_reg[5];

`ifndef SYNTHESIS
    // An empty output stage means nothing can block the input.
    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked while output stage empty");

    // An empty first stage always takes a transfer.
    a_first_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[0] |-> s_ready)
        else $error("first stage empty but not ready");

    // An accepted transfer lands in stage one.
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted transfer lost at stage one");

    // A stalled result is held, and the stage behind it keeps its item.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && vld_reg[4]) |=> (m_valid && vld_reg[4]))
        else $error("item dropped during output stall");
`endif

endmodule

// ----- rtl/hsv2rgb_channel.sv -----
// One colour channel: weighted sum, scaling, division by 40000 and clamp.
`timescale 1ns / 1ps

module hsv2rgb_channel
    import hsv2rgb_pkg::*;
(
    input  logic        aclk,
    input  chan_en_t    en,
    input  logic [19:0] v6000,     // 6000 * V
    input  logic [13:0] sv,        // S * V
    input  logic [5:0]  weight,    // 60 - k for this channel's component
    output logic [7:0]  code
);

    logic [19:0] num_reg, num_next;
    logic [17:0] t_reg, t_next;
    logic [17:0] t5_reg;
    logic [8:0]  q0_reg, q0_next;
    logic [7:0]  code_reg, code_next;

    logic [23:0] scaled;
    logic [32:0] prod;
    logic [18:0] q_mul;
    logic        q_inc;
    logic [9:0]  q_sum;

    // Stage 3: numerator over 600000, never negative.
    assign num_next = v6000 - 20'(weight) * 20'(sv);

    // Stage 4: 17 * num + half, then drop the power-of-two part of 40000.
    assign scaled = 24'(num_reg * 24'(CHAN_MUL)) + 24'(ROUND_OFS);
    assign t_next = scaled[23:DIV_SHIFT];

    // Stage 5: reciprocal estimate of t / 625, low by at most one.
    assign prod    = 33'(t_reg) * 33'(RECIP);
    assign q0_next = prod[32:RECIP_SH];

    // Stage 6: one correction step, then clamp.
    assign q_mul = 19'(q0_reg) * 19'(DIV_REM);
    assign q_inc = (19'(t5_reg) >= (q_mul + 19'(DIV_REM)));
    assign q_sum = 10'(q0_reg) + 10'(q_inc);
    assign code_next = (q_sum > 10'(CODE_MAX)) ? 8'(CODE_MAX) : q_sum[7:0];

    always_ff @(posedge aclk) begin
        if (en.en3) begin
            num_reg <= num_next;
        end
        if (en.en4) begin
            t_reg <= t_next;
        end
        if (en.en5) begin
            q0_reg <= q0_next;
            t5_reg <= t_reg;
        end
        if (en.en6) begin
            code_reg <= code_next;
        end
    end

    assign code = code_reg;

endmodule
